@@ src/cmpd_pkg.sv @@
package cmpd_pkg;

    localparam int unsigned MotorFrameLen = 18;
    localparam int unsigned ThrPosOffset  = 1048;
    localparam int unsigned ThrPosMax     = 2047;
    localparam int unsigned ThrNegOffset  = 48;
    localparam int unsigned ThrNegMax     = 1047;
    localparam int unsigned PwmCentre     = 120000;

    localparam logic KindAck   = 1'b0;
    localparam logic KindMotor = 1'b1;

    typedef struct packed {
        logic       store_wr;
        logic       clr_count;
        logic       rd_req;
        logic [7:0] rd_addr;
        logic       walk_start;
        logic       walk_step;
        logic       sum_step;
        logic       lo_step;
        logic       hi_step;
    } t_cmd;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] rd_data;
        logic       full_next;
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ack_byte;
        logic [2:0]  channel;
        logic [15:0] motor_command;
        logic [15:0] dshot_frame;
        logic [17:0] pwm_counts;
        logic        last;
    } t_result;

    function automatic logic [15:0] dshot_encode(input logic signed [15:0] cmd);
        logic [11:0] thr;
        logic [16:0] mag;
        logic [15:0] f;
        thr = '0;
        mag = '0;
        if (cmd > 0) begin
            thr = 12'(cmd[14:5]) + 12'(ThrPosOffset);
            if (thr > 12'(ThrPosMax)) begin
                thr = 12'(ThrPosMax);
            end
        end else if (cmd < 0) begin
            mag = 17'(-(17'(signed'(cmd))));
            thr = 12'(mag[16:5]) + 12'(ThrNegOffset);
            if (thr > 12'(ThrNegMax)) begin
                thr = 12'(ThrNegMax);
            end
        end
        f = {thr[10:0], 5'd0};
        return {f[15:4], f[15:12] ^ f[11:8] ^ f[7:4]};
    endfunction

    function automatic logic [17:0] pwm_encode(input logic signed [15:0] cmd);
        logic signed [18:0] p;
        logic signed [18:0] q;
        p = 19'(signed'(cmd)) * 19'sd5;
        q = (p < 0) ? -((-p) >>> 2) : (p >>> 2);
        return 18'(q + 19'(PwmCentre));
    endfunction

endpackage

@@ src/cmpd_ram.sv @@
module cmpd_ram #(
    parameter int Width = 8,
    parameter int Depth = 50
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ src/cmpd_datapath.sv @@
module cmpd_datapath #(
    parameter int FrameBytes = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  cmpd_pkg::t_cmd   i_cmd,
    output cmpd_pkg::t_status o_status,
    output logic [7:0]       o_sum,
    output logic [7:0]       o_lo,
    output logic             o_on_chain
);

    localparam int Aw = $clog2(FrameBytes);

    logic [7:0]  r_count;
    logic [7:0]  r_next;
    logic [7:0]  r_sum;
    logic [7:0]  r_lo;
    logic [7:0]  r_idx;
    logic [7:0]  w_rd;
    logic        w_chain;
    logic        w_zero;
    logic        w_we;
    logic [7:0]  w_wdata;
    logic [Aw-1:0] w_waddr;

    // A byte on the offset chain is cleared in the store as the walk passes it.
    assign w_zero  = i_cmd.walk_step && w_chain;
    assign w_we    = i_cmd.store_wr || w_zero;
    assign w_waddr = w_zero ? r_idx[Aw-1:0] : r_count[Aw-1:0];
    assign w_wdata = w_zero ? 8'd0 : i_byte;

    cmpd_ram #(.Width(8), .Depth(FrameBytes)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_cmd.rd_addr[Aw-1:0]),
        .o_rdata(w_rd)
    );

    assign w_chain = (r_idx == r_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.store_wr) begin
            r_count <= (r_count + 8'd1 >= 8'(FrameBytes)) ? 8'd0 : r_count + 8'd1;
        end
        if (i_cmd.rd_req) begin
            r_idx <= i_cmd.rd_addr;
        end
        if (i_cmd.walk_start) begin
            r_next <= w_rd;
            r_sum  <= '0;
        end else if (i_cmd.walk_step && w_chain) begin
            r_next <= r_next + w_rd;
        end
        if (i_cmd.sum_step) begin
            r_sum <= r_sum + (w_chain ? 8'd0 : w_rd);
        end
        if (i_cmd.lo_step) begin
            r_lo <= w_rd;
        end
    end

    assign o_status.count     = r_count;
    assign o_status.rd_data   = w_rd;
    assign o_status.full_next = (r_count + 8'd1 >= 8'(FrameBytes));
    assign o_sum      = r_sum;
    assign o_lo       = r_lo;
    assign o_on_chain = w_chain;

endmodule

@@ src/cmpd_ctrl.sv @@
module cmpd_ctrl #(
    parameter int FrameBytes    = 50,
    parameter int MotorChannels = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [7:0]         i_byte,
    output logic               o_in_ready,
    input  cmpd_pkg::t_status  i_status,
    input  logic [7:0]         i_sum,
    input  logic [7:0]         i_lo,
    input  logic               i_on_chain,
    output cmpd_pkg::t_cmd     o_cmd,
    output logic               o_res_valid,
    output cmpd_pkg::t_result  o_res,
    input  logic               i_res_ready
);

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StFirst = 3'd1;
    localparam logic [2:0] StWalk  = 3'd2;
    localparam logic [2:0] StAck   = 3'd3;
    localparam logic [2:0] StLo    = 3'd4;
    localparam logic [2:0] StHi    = 3'd5;
    localparam logic [2:0] StOut   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [7:0] r_n;
    logic [7:0] r_i, n_i;
    logic [2:0] r_ch, n_ch;
    logic       r_motor;
    logic       r_ok, n_ok;
    logic       w_acc;
    logic [7:0] w_rd;
    logic signed [15:0] w_cmd;

    assign w_rd  = i_status.rd_data;
    assign w_acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == StIdle);
    assign w_cmd = signed'({w_rd, i_lo});

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_ch    = r_ch;
        n_ok    = r_ok;
        o_cmd   = '0;
        unique case (r_state)
            StIdle: begin
                if (w_acc) begin
                    if (i_byte != 8'd0) begin
                        o_cmd.store_wr = 1'b1;
                    end else begin
                        o_cmd.clr_count = 1'b1;
                        if (i_status.count >= 8'd2) begin
                            o_cmd.rd_req  = 1'b1;
                            o_cmd.rd_addr = 8'd0;
                            n_state = StFirst;
                        end
                    end
                end
            end
            StFirst: begin
                o_cmd.walk_start = 1'b1;
                if (w_rd > r_n) begin
                    n_state = StIdle;
                end else begin
                    o_cmd.rd_req  = 1'b1;
                    o_cmd.rd_addr = 8'd1;
                    n_i = 8'd1;
                    n_state = StWalk;
                end
            end
            StWalk: begin
                o_cmd.walk_step = 1'b1;
                if (r_i == r_n - 8'd1) begin
                    n_ok = ((i_on_chain ? 8'd0 : w_rd) == i_sum);
                    n_state = n_ok ? StAck : StIdle;
                end else begin
                    o_cmd.sum_step = 1'b1;
                    o_cmd.rd_req  = 1'b1;
                    o_cmd.rd_addr = r_i + 8'd1;
                    n_i = r_i + 8'd1;
                end
            end
            StAck: begin
                if (i_res_ready) begin
                    if (r_motor) begin
                        n_ch = '0;
                        o_cmd.rd_req  = 1'b1;
                        o_cmd.rd_addr = 8'd1;
                        n_state = StLo;
                    end else begin
                        n_state = StIdle;
                    end
                end
            end
            StLo: begin
                o_cmd.lo_step = 1'b1;
                o_cmd.rd_req  = 1'b1;
                o_cmd.rd_addr = {4'd0, r_ch, 1'b0} + 8'd2;
                n_state = StHi;
            end
            StHi: begin
                o_cmd.hi_step = 1'b1;
                n_state = StOut;
            end
            StOut: begin
                if (i_res_ready) begin
                    if (32'(r_ch) == MotorChannels - 1) begin
                        n_state = StIdle;
                    end else begin
                        n_ch = r_ch + 3'd1;
                        o_cmd.rd_req  = 1'b1;
                        o_cmd.rd_addr = {4'd0, n_ch, 1'b0} + 8'd1;
                        n_state = StLo;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    // Chain entries are cleared in the store as the walk passes them; the byte being
    // cleared is masked in the running sum and in the final compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            o_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == StWalk && n_state == StAck) begin
                o_res_valid <= 1'b1;
                o_res <= '{kind: cmpd_pkg::KindAck, ack_byte: i_sum, channel: 3'd0,
                           motor_command: 16'd0, dshot_frame: 16'd0, pwm_counts: 18'd0,
                           last: !r_motor};
            end else if (r_state == StHi) begin
                o_res_valid <= 1'b1;
                o_res <= '{kind: cmpd_pkg::KindMotor, ack_byte: 8'd0, channel: r_ch,
                           motor_command: w_cmd,
                           dshot_frame: cmpd_pkg::dshot_encode(w_cmd),
                           pwm_counts: cmpd_pkg::pwm_encode(w_cmd),
                           last: (32'(r_ch) == MotorChannels - 1)};
            end else if (o_res_valid && i_res_ready) begin
                o_res_valid <= 1'b0;
            end
        end
        if (r_state == StIdle && w_acc) begin
            r_n     <= i_status.count;
            r_motor <= (i_status.count == 8'(cmpd_pkg::MotorFrameLen));
        end
        r_i  <= n_i;
        r_ch <= n_ch;
        r_ok <= n_ok;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != StIdle) |-> !o_in_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid)
        else $error("result dropped");
    a_ack_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StWalk && n_state == StAck) |=> (o_res.kind == cmpd_pkg::KindAck))
        else $error("acknowledge not first");
`endif

endmodule

@@ src/cobs_motor_packet_to_dshot_top.sv @@
// Serial motor packet deframer with DShot and PWM encoding.
// Input: one received byte per item on the s_axis channel; a zero byte ends a frame.
// Nonzero bytes are written into a frame store, one item per cycle, back to back, while the controller is idle.
// At a frame end of n stored bytes the controller walks the store once, one byte per
// cycle from its single read port, clearing the offset chain and summing; the
// acknowledge is registered when the walk reaches the last stored byte.
// A matching checksum gives an acknowledge item; an 18-byte frame then gives eight
// motor items, each one read and encoded after the receiver takes the item before it.
// No item is accepted from the frame end until the last result of that frame is taken.
// A dropped frame frees the input sooner; a frame end with fewer than two bytes at once.
// Results sit in an output register; a stall on m_axis_tready holds the result and
// the controller waits. Up to 9 items result from one frame end, the last with tlast.
// Reset clears the byte count, the controller state and the output valid; the
// frame store needs no clearing since only bytes written in the current frame are read.
// m_axis_tuser carries kind (0 acknowledge, 1 motor command).
module cobs_motor_packet_to_dshot_top #(
    parameter int FRAME_BYTES    = 50,
    parameter int MOTOR_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // ack_byte, channel, motor_command, dshot_frame, pwm_counts
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    cmpd_pkg::t_cmd    w_cmd;
    cmpd_pkg::t_status w_status;
    cmpd_pkg::t_result w_res;
    logic [7:0] w_sum, w_lo;
    logic       w_chain;

    cmpd_datapath #(.FrameBytes(FRAME_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_byte(s_axis_tdata), .i_cmd(w_cmd),
        .o_status(w_status), .o_sum(w_sum), .o_lo(w_lo),
        .o_on_chain(w_chain)
    );

    cmpd_ctrl #(.FrameBytes(FRAME_BYTES), .MotorChannels(MOTOR_CHANNELS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_byte(s_axis_tdata), .o_in_ready(s_axis_tready), .i_status(w_status),
        .i_sum(w_sum), .i_lo(w_lo), .i_on_chain(w_chain),
        .o_cmd(w_cmd), .o_res_valid(m_axis_tvalid), .o_res(w_res),
        .i_res_ready(m_axis_tready)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;
    assign m_axis_tdata = {3'd0, w_res.pwm_counts, w_res.dshot_frame,
                           w_res.motor_command, w_res.channel, w_res.ack_byte};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    class frame_scoreboard;
        logic [7:0] frame_buf[50];
        int unsigned byte_count;
        cmpd_pkg::t_result expected_q[$];
        int errors;
        int results_seen;

        function new();
            byte_count = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function logic [15:0] dshot_of(logic signed [15:0] cmd);
            int thr;
            logic [15:0] f;
            int mag;
            thr = 0;
            if (cmd > 0) begin
                thr = (int'(cmd) >>> 5) + int'(cmpd_pkg::ThrPosOffset);
                if (thr > int'(cmpd_pkg::ThrPosMax)) begin
                    thr = int'(cmpd_pkg::ThrPosMax);
                end
            end else if (cmd < 0) begin
                mag = -int'(cmd);
                thr = (mag >>> 5) + int'(cmpd_pkg::ThrNegOffset);
                if (thr > int'(cmpd_pkg::ThrNegMax)) begin
                    thr = int'(cmpd_pkg::ThrNegMax);
                end
            end
            f = 16'(thr << 5);
            return {f[15:4], f[15:12] ^ f[11:8] ^ f[7:4]};
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned n;
            int unsigned nxt;
            logic [7:0] sum;
            int signed cmd;
            cmpd_pkg::t_result r;
            if (b != 0) begin
                frame_buf[byte_count] = b;
                byte_count++;
                if (byte_count >= 50) begin
                    byte_count = 0;
                end
                return;
            end
            n = byte_count;
            byte_count = 0;
            if (n < 2) begin
                return;
            end
            nxt = frame_buf[0];
            if (nxt > n) begin
                return;
            end
            for (int unsigned i = 0; i < n; i++) begin
                if (i == nxt) begin
                    nxt = (nxt + frame_buf[i]) & 8'hFF;
                    frame_buf[i] = 8'd0;
                end
            end
            sum = 8'd0;
            for (int unsigned i = 1; i + 1 < n; i++) begin
                sum += frame_buf[i];
            end
            if (sum != frame_buf[n - 1]) begin
                return;
            end
            r = '0;
            r.kind = cmpd_pkg::KindAck;
            r.ack_byte = sum;
            r.last = (n != cmpd_pkg::MotorFrameLen);
            expected_q.push_back(r);
            if (n == cmpd_pkg::MotorFrameLen) begin
                for (int c = 0; c < 8; c++) begin
                    r = '0;
                    r.kind = cmpd_pkg::KindMotor;
                    r.channel = 3'(c);
                    r.motor_command = {frame_buf[2 * c + 2], frame_buf[2 * c + 1]};
                    cmd = int'(signed'(r.motor_command));
                    r.dshot_frame = dshot_of(r.motor_command);
                    r.pwm_counts = 18'((cmd * 5) / 4 + int'(cmpd_pkg::PwmCentre));
                    r.last = (c == 7);
                    expected_q.push_back(r);
                end
            end
        endfunction

        function void check_result(cmpd_pkg::t_result got);
            cmpd_pkg::t_result exp_r;
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    frame_scoreboard sb;
    bit quiet;
    int frames_sent;

    cobs_motor_packet_to_dshot_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The valid stays high after an accepted item so that items can follow back to back.
    task automatic send_byte(logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
    endtask

    // Builds an encoded frame from a decoded payload with a correct checksum,
    // optionally spoiling the checksum, then sends it with its closing zero.
    task automatic send_frame(int unsigned len, bit bad_sum, bit full_range);
        logic [7:0] dec[50];
        logic [7:0] enc[50];
        logic [7:0] sum;
        int unsigned last_zero;
        sum = 8'd0;
        dec[0] = 8'd0;
        for (int unsigned i = 1; i + 1 < len; i++) begin
            dec[i] = ($urandom_range(0, 5) == 0) ? 8'd0 :
                     (full_range ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15)));
            sum += dec[i];
        end
        dec[len - 1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
        last_zero = len;
        for (int i = int'(len) - 1; i >= 0; i--) begin
            if (dec[i] == 0) begin
                enc[i] = 8'(last_zero - i);
                last_zero = i;
            end else begin
                enc[i] = dec[i];
            end
        end
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(enc[i]);
        end
        send_byte(8'd0);
        frames_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result('{kind: m_axis_tuser, ack_byte: m_axis_tdata[7:0],
                    channel: m_axis_tdata[10:8], motor_command: m_axis_tdata[26:11],
                    dshot_frame: m_axis_tdata[42:27], pwm_counts: m_axis_tdata[60:43],
                    last: m_axis_tlast});
            end
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        sb = new();
        quiet = 1'b0;
        frames_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short frames, chain start past the end, extreme commands,
        // a mismatched sum and a store overflow followed by a short valid frame.
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'd0);
        send_byte(8'd9);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'd1);
        send_byte(8'd0);
        send_byte(8'd18);
        for (int i = 0; i < 8; i++) begin
            send_byte(i[0] ? 8'h80 : 8'hFF);
            send_byte(i[1] ? 8'h7F : 8'h80);
        end
        send_byte(8'hF8);
        send_byte(8'd0);
        send_frame(18, 1'b1, 1'b1);
        drain();
        for (int i = 0; i < 50; i++) begin
            send_byte(8'($urandom_range(1, 255)));
        end
        send_frame(5, 1'b0, 1'b0);
        drain();

        // Random: mostly well-formed frames, some broken ones and noise.
        for (int f = 0; f < 2; f++) begin
            if (f >= 1) begin
                quiet = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom_range(0, 255)));
                1: send_frame(18, 1'b1, $urandom_range(0, 1));
                2: send_frame($urandom_range(2, 20), 1'b0, $urandom_range(0, 1));
                default: send_frame(18, 1'b0, $urandom_range(0, 1));
            endcase
        end
        send_byte(8'd0);
        drain();

        $display("Sent %0d frames; %0d results checked, acknowledges and motor commands.",
                 frames_sent, sb.results_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
